### hdl/sorted_edge_table_engine_defines.svh
// Assertion macros shared by the checker of the sorted edge table engine.
// Depends on nothing; included by the checker file.
`ifndef SORTED_EDGE_TABLE_ENGINE_DEFINES_SVH
`define SORTED_EDGE_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SETE_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("sorted edge table engine check failed");

// Next-cycle implication, disabled while reset is held.
`define SETE_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sorted edge table engine check failed");

`endif

### hdl/sete_pkg.sv
// Package of the sorted edge table engine: operation and status codes,
// field widths, default sizes and the link table row type. No dependencies.
`default_nettype none
package sete_pkg;
  localparam int FUNC_W   = 3;
  localparam int NODE_W   = 6;
  localparam int LABEL_W  = 16;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int LPOS_W   = 9;
  localparam int TOTAL_W  = 9;
  localparam int DEG_W    = 7;
  localparam int FOUT_W   = 9;
  localparam int FIN_W    = 8;
  localparam int NCNT_W   = 7;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_LINKS = 256;
  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd16;

  localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RDLINK = 3'd3;
  localparam logic [FUNC_W-1:0] FN_BUILD  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RDORD  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD         = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_INDEXED = 3'd4;

  typedef struct packed {
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  dst;
    logic [LABEL_W-1:0] label;
  } link_t;
endpackage
`default_nettype wire

### hdl/sete_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module sete_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/sorted_edge_table_engine.sv
// Each word runs through the sequencer: a find walks the sorted link table, an add or
// remove also shifts the table and sweeps every node row, a build sweeps the nodes then every link.
// Throughput: one word at a time; the next word is taken once the sequencer is back
// in idle, after the result has been handed to the output register.
// Reset (synchronous, rst_n low): empty table, index invalid, all nodes read as
// degree zero with no first link, node_count 16. No clearing pass is needed.
`default_nettype none
module sorted_edge_table_engine #(
  parameter int MAX_NODES = sete_pkg::DEF_MAX_NODES,
  parameter int MAX_LINKS = sete_pkg::DEF_MAX_LINKS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic        [sete_pkg::NCNT_W-1:0]   cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic        [sete_pkg::FUNC_W-1:0]   in_func,
  input  wire logic        [sete_pkg::NODE_W-1:0]   in_source_node,
  input  wire logic        [sete_pkg::NODE_W-1:0]   in_dest_node,
  input  wire logic signed [sete_pkg::LABEL_W-1:0]  in_user_link_id,
  input  wire logic        [sete_pkg::POS_W-1:0]    in_position,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [sete_pkg::STATUS_W-1:0] out_status,
  output logic signed      [sete_pkg::LPOS_W-1:0]   out_link_pos,
  output logic             [sete_pkg::NODE_W-1:0]   out_link_source,
  output logic             [sete_pkg::NODE_W-1:0]   out_link_dest,
  output logic signed      [sete_pkg::LABEL_W-1:0]  out_link_label,
  output logic             [sete_pkg::TOTAL_W-1:0]  out_total_links,
  output logic             [sete_pkg::DEG_W-1:0]    out_node_out_degree,
  output logic             [sete_pkg::DEG_W-1:0]    out_node_in_degree,
  output logic signed      [sete_pkg::FOUT_W-1:0]   out_node_first_out,
  output logic             [sete_pkg::FIN_W-1:0]    out_node_first_in
);
  import sete_pkg::*;

  // Derived widths: node index, table position, link count, degree, first-out.
  localparam int NW  = $clog2(MAX_NODES);
  localparam int PW  = $clog2(MAX_LINKS);
  localparam int LCW = $clog2(MAX_LINKS + 1);
  localparam int DW  = $clog2(MAX_NODES + 1);
  localparam int FOW = PW + 1;
  localparam int LW  = (DW > NCNT_W) ? DW : NCNT_W;
  localparam int PCW = (LCW > POS_W) ? LCW : POS_W;
  localparam int LRW = $bits(link_t);

  // Sequencer states.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SCAN_RD  = 5'd1;
  localparam logic [4:0] S_SCAN_CHK = 5'd2;
  localparam logic [4:0] S_DECIDE   = 5'd3;
  localparam logic [4:0] S_SHUP_RD  = 5'd4;
  localparam logic [4:0] S_SHUP_WR  = 5'd5;
  localparam logic [4:0] S_INS_WR   = 5'd6;
  localparam logic [4:0] S_NODE_RD  = 5'd7;
  localparam logic [4:0] S_NODE_WR  = 5'd8;
  localparam logic [4:0] S_SHDN_RD  = 5'd9;
  localparam logic [4:0] S_SHDN_WR  = 5'd10;
  localparam logic [4:0] S_BLD_RD   = 5'd11;
  localparam logic [4:0] S_BLD_WR   = 5'd12;
  localparam logic [4:0] S_SORT_LNK = 5'd13;
  localparam logic [4:0] S_SORT_FIL = 5'd14;
  localparam logic [4:0] S_SORT_WR  = 5'd15;
  localparam logic [4:0] S_RD_ORD   = 5'd16;
  localparam logic [4:0] S_RD_ORD_W = 5'd17;
  localparam logic [4:0] S_RD_LNK   = 5'd18;
  localparam logic [4:0] S_RD_LNK_W = 5'd19;
  localparam logic [4:0] S_Q_RD     = 5'd20;
  localparam logic [4:0] S_Q_W      = 5'd21;
  localparam logic [4:0] S_DONE     = 5'd22;

  // One row of per-node bookkeeping, kept in a single node RAM.
  typedef struct packed {
    logic        [DW-1:0]  od;
    logic        [DW-1:0]  id;
    logic signed [FOW-1:0] fo;
    logic        [LCW-1:0] fi;
  } node_row_t;
  localparam int NRW = $bits(node_row_t);
  localparam node_row_t NODE_RST = '{od: '0, id: '0, fo: '1, fi: '0};

  // Control state.
  logic [4:0]           state_r;
  logic [NCNT_W-1:0]    node_count_r;
  logic [LCW-1:0]       lc_r;
  logic                 ov_r;
  logic [MAX_NODES-1:0] node_vld_r;
  logic                 nrow_vld_r;
  logic                 out_valid_r;

  // Working registers of the current word.
  logic [FUNC_W-1:0]  func_r;
  logic [NODE_W-1:0]  src_r;
  logic [NODE_W-1:0]  dst_r;
  logic [LABEL_W-1:0] lab_r;
  logic [LCW-1:0]     k_r;
  logic [LCW-1:0]     j_r;
  logic [NW-1:0]      x_r;
  logic [NW-1:0]      y_r;
  logic [PW-1:0]      a_r;
  logic [LCW-1:0]     sum_r;
  logic               found_r;

  // Result being assembled, and the output register.
  logic [STATUS_W-1:0] res_status_r, out_status_r;
  logic [LPOS_W-1:0]   res_lpos_r, out_lpos_r;
  logic [NODE_W-1:0]   res_ls_r, out_ls_r;
  logic [NODE_W-1:0]   res_ld_r, out_ld_r;
  logic [LABEL_W-1:0]  res_ll_r, out_ll_r;
  logic [DEG_W-1:0]    res_od_r, out_od_r;
  logic [DEG_W-1:0]    res_id_r, out_id_r;
  logic [FOUT_W-1:0]   res_fo_r, out_fo_r;
  logic [FIN_W-1:0]    res_fi_r, out_fi_r;
  logic [TOTAL_W-1:0]  out_total_r;

  // RAM ports.
  logic           link_we;
  logic [PW-1:0]  link_waddr, link_raddr;
  link_t          link_wdata, link_rdata;
  logic           node_we;
  logic [NW-1:0]  node_waddr, node_raddr;
  node_row_t      node_wdata, node_rdata;
  logic           fill_we;
  logic [NW-1:0]  fill_waddr, fill_raddr;
  logic [LCW-1:0] fill_wdata, fill_rdata;
  logic           ord_we;
  logic [PW-1:0]  ord_waddr;
  logic [PW-1:0]  ord_wdata, ord_rdata;

  // Helpers.
  logic [LW-1:0] lim;
  logic          src_bad, dst_bad, pos_bad;
  logic          accept;
  logic          x_is_s, x_is_d, x_last;
  logic          key_eq, key_after;
  node_row_t     row_cur, row_add, row_rem;
  logic          fill_ok;

  sete_ram #(.WIDTH(LRW), .DEPTH(MAX_LINKS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );
  sete_ram #(.WIDTH(NRW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );
  sete_ram #(.WIDTH(LCW), .DEPTH(MAX_NODES)) u_fill_ram (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );
  sete_ram #(.WIDTH(PW), .DEPTH(MAX_LINKS)) u_order_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(a_r), .rdata(ord_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // The node limit is the smaller of the register and the node RAM depth.
  assign lim = (LW'(node_count_r) < LW'(MAX_NODES)) ? LW'(node_count_r) : LW'(MAX_NODES);
  assign src_bad = (LW'(in_source_node) >= lim);
  assign dst_bad = (LW'(in_dest_node) >= lim);
  assign pos_bad = (PCW'(in_position) >= PCW'(lc_r));

  // Shared compare unit of the table walk: the key against the entry just read.
  assign key_eq    = (link_rdata.src == src_r) && (link_rdata.dst == dst_r);
  assign key_after = (link_rdata.src > src_r) ||
                     ((link_rdata.src == src_r) && (link_rdata.dst > dst_r));

  assign x_is_s = (x_r == NW'(src_r));
  assign x_is_d = (x_r == NW'(dst_r));
  assign x_last = (x_r == NW'(MAX_NODES - 1));
  assign fill_ok = (fill_rdata < LCW'(MAX_LINKS));

  // A node row that was never written reads as its reset value.
  assign row_cur = nrow_vld_r ? node_rdata : NODE_RST;

  // Node sweep after an insertion at k: shift later first-out positions up, count the new
  // link at its source and destination, and give a source with no first-out the position k.
  always_comb begin
    row_add = row_cur;
    if (x_is_s) begin
      row_add.od = row_cur.od + DW'(1);
      if (row_cur.fo[FOW-1]) begin
        row_add.fo = $signed({1'b0, k_r[PW-1:0]});
      end
    end else if (!row_cur.fo[FOW-1] && (row_cur.fo[PW-1:0] >= k_r[PW-1:0])) begin
      row_add.fo = row_cur.fo + FOW'(1);
    end
    if (x_is_d) begin
      row_add.id = row_cur.id + DW'(1);
    end
  end

  // Node sweep after a removal at k: uncount the link, drop the first-out of a
  // source left empty, then shift later first-out positions down.
  always_comb begin
    row_rem = row_cur;
    if (x_is_s) begin
      row_rem.od = row_cur.od - DW'(1);
      if (row_rem.od == '0) begin
        row_rem.fo = '1;
      end
    end
    if (x_is_d) begin
      row_rem.id = row_cur.id - DW'(1);
    end
    if (!row_rem.fo[FOW-1] && (row_rem.fo[PW-1:0] > k_r[PW-1:0])) begin
      row_rem.fo = row_rem.fo - FOW'(1);
    end
  end

  // RAM address and write control, decoded from the sequencer state.
  always_comb begin
    link_raddr = k_r[PW-1:0];
    link_we    = 1'b0;
    link_waddr = j_r[PW-1:0];
    link_wdata = link_rdata;
    node_raddr = x_r;
    node_we    = 1'b0;
    node_waddr = x_r;
    node_wdata = row_cur;
    fill_raddr = NW'(link_rdata.dst);
    fill_we    = 1'b0;
    fill_waddr = x_r;
    fill_wdata = sum_r;
    ord_we     = 1'b0;
    ord_waddr  = fill_rdata[PW-1:0];
    ord_wdata  = k_r[PW-1:0];
    unique case (state_r)
      S_SHUP_RD: link_raddr = PW'(j_r - LCW'(1));
      S_SHUP_WR: link_we = 1'b1;
      S_INS_WR: begin
        link_we    = 1'b1;
        link_waddr = k_r[PW-1:0];
        link_wdata = '{src: src_r, dst: dst_r, label: lab_r};
      end
      S_SHDN_RD: link_raddr = PW'(j_r + LCW'(1));
      S_SHDN_WR: link_we = 1'b1;
      S_NODE_WR: begin
        node_we    = 1'b1;
        node_wdata = (func_r == FN_ADD) ? row_add : row_rem;
      end
      S_BLD_WR: begin
        node_we       = 1'b1;
        node_wdata    = row_cur;
        node_wdata.fi = sum_r;
        fill_we       = 1'b1;
      end
      S_SORT_WR: begin
        ord_we     = fill_ok;
        fill_we    = fill_ok;
        fill_waddr = y_r;
        fill_wdata = fill_rdata + LCW'(1);
      end
      S_RD_LNK: link_raddr = a_r;
      S_Q_RD:   node_raddr = NW'(src_r);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      lc_r         <= '0;
      ov_r         <= 1'b0;
      node_vld_r   <= '0;
      nrow_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
      nrow_vld_r <= node_vld_r[node_raddr];
      if (node_we) begin
        node_vld_r[node_waddr] <= 1'b1;
      end
      // The done state reloads the output register itself in the cycle it hands over.
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            func_r       <= in_func;
            src_r        <= in_source_node;
            dst_r        <= in_dest_node;
            lab_r        <= in_user_link_id;
            a_r          <= PW'(in_position);
            k_r          <= '0;
            x_r          <= '0;
            sum_r        <= '0;
            res_status_r <= ST_OK;
            res_lpos_r   <= '1;
            res_ls_r     <= '0;
            res_ld_r     <= '0;
            res_ll_r     <= '0;
            res_od_r     <= '0;
            res_id_r     <= '0;
            res_fo_r     <= '1;
            res_fi_r     <= '0;
            unique case (in_func)
              FN_ADD, FN_REMOVE, FN_FIND: begin
                if (src_bad || dst_bad) begin
                  res_status_r <= ST_BAD;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_SCAN_RD;
                end
              end
              FN_RDLINK: begin
                if (pos_bad) begin
                  res_status_r <= ST_BAD;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_RD_LNK;
                end
              end
              FN_RDORD: begin
                if (!ov_r) begin
                  res_status_r <= ST_NOT_INDEXED;
                  state_r      <= S_DONE;
                end else if (pos_bad) begin
                  res_status_r <= ST_BAD;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_RD_ORD;
                end
              end
              FN_BUILD: state_r <= S_BLD_RD;
              FN_QUERY: begin
                if (src_bad) begin
                  res_status_r <= ST_BAD;
                  state_r      <= S_DONE;
                end else begin
                  state_r <= S_Q_RD;
                end
              end
              default: begin
                res_status_r <= ST_BAD;
                state_r      <= S_DONE;
              end
            endcase
          end
        end

        // Walk the sorted table until the key, the first entry after it or the end of the table.
        S_SCAN_RD: begin
          if (k_r == lc_r) begin
            found_r <= 1'b0;
            state_r <= S_DECIDE;
          end else begin
            state_r <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (key_eq) begin
            found_r <= 1'b1;
            state_r <= S_DECIDE;
          end else if (key_after) begin
            found_r <= 1'b0;
            state_r <= S_DECIDE;
          end else begin
            k_r     <= k_r + LCW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_DECIDE: begin
          unique case (func_r)
            FN_ADD: begin
              if (found_r) begin
                res_lpos_r <= LPOS_W'(k_r);
                state_r    <= S_DONE;
              end else if (lc_r == LCW'(MAX_LINKS)) begin
                res_status_r <= ST_FULL;
                state_r      <= S_DONE;
              end else begin
                res_lpos_r <= LPOS_W'(k_r);
                j_r        <= lc_r;
                state_r    <= (lc_r == k_r) ? S_INS_WR : S_SHUP_RD;
              end
            end
            FN_REMOVE: begin
              if (found_r) begin
                res_lpos_r <= LPOS_W'(k_r);
                state_r    <= S_NODE_RD;
              end else begin
                res_status_r <= ST_NOT_FOUND;
                state_r      <= S_DONE;
              end
            end
            default: begin
              if (found_r) begin
                res_lpos_r <= LPOS_W'(k_r);
              end else begin
                res_status_r <= ST_NOT_FOUND;
              end
              state_r <= S_DONE;
            end
          endcase
        end

        // Open a gap at k by moving entries up one place, top first.
        S_SHUP_RD: state_r <= S_SHUP_WR;
        S_SHUP_WR: begin
          j_r     <= j_r - LCW'(1);
          state_r <= ((j_r - LCW'(1)) == k_r) ? S_INS_WR : S_SHUP_RD;
        end
        S_INS_WR: begin
          lc_r    <= lc_r + LCW'(1);
          ov_r    <= 1'b0;
          state_r <= S_NODE_RD;
        end

        // Read-modify-write sweep over every node row.
        S_NODE_RD: state_r <= S_NODE_WR;
        S_NODE_WR: begin
          if (x_last) begin
            j_r     <= k_r;
            state_r <= (func_r == FN_ADD) ? S_DONE : S_SHDN_RD;
          end else begin
            x_r     <= x_r + NW'(1);
            state_r <= S_NODE_RD;
          end
        end

        // Close the gap at k by moving later entries down one place.
        S_SHDN_RD: begin
          if ((j_r + LCW'(1)) >= lc_r) begin
            lc_r    <= lc_r - LCW'(1);
            ov_r    <= 1'b0;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SHDN_WR;
          end
        end
        S_SHDN_WR: begin
          j_r     <= j_r + LCW'(1);
          state_r <= S_SHDN_RD;
        end

        // Index build: prefix sum of in degrees into first-in and fill pointers.
        S_BLD_RD: state_r <= S_BLD_WR;
        S_BLD_WR: begin
          sum_r <= sum_r + LCW'(row_cur.id);
          if (x_last) begin
            state_r <= S_SORT_LNK;
          end else begin
            x_r     <= x_r + NW'(1);
            state_r <= S_BLD_RD;
          end
        end
        // Counting sort: each link goes to its destination's fill pointer.
        S_SORT_LNK: begin
          if (k_r == lc_r) begin
            ov_r    <= 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_SORT_FIL;
          end
        end
        S_SORT_FIL: begin
          y_r     <= NW'(link_rdata.dst);
          state_r <= S_SORT_WR;
        end
        S_SORT_WR: begin
          k_r     <= k_r + LCW'(1);
          state_r <= S_SORT_LNK;
        end

        S_RD_ORD:   state_r <= S_RD_ORD_W;
        S_RD_ORD_W: begin
          a_r     <= ord_rdata;
          state_r <= S_RD_LNK;
        end
        S_RD_LNK:   state_r <= S_RD_LNK_W;
        S_RD_LNK_W: begin
          res_lpos_r <= LPOS_W'(a_r);
          res_ls_r   <= link_rdata.src;
          res_ld_r   <= link_rdata.dst;
          res_ll_r   <= link_rdata.label;
          state_r    <= S_DONE;
        end

        S_Q_RD: state_r <= S_Q_W;
        S_Q_W: begin
          res_od_r <= DEG_W'(row_cur.od);
          res_id_r <= DEG_W'(row_cur.id);
          res_fo_r <= FOUT_W'(row_cur.fo);
          res_fi_r <= ov_r ? FIN_W'(row_cur.fi) : '0;
          state_r  <= S_DONE;
        end

        // Hand the result to the output register once it is free.
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_lpos_r   <= res_lpos_r;
            out_ls_r     <= res_ls_r;
            out_ld_r     <= res_ld_r;
            out_ll_r     <= res_ll_r;
            out_total_r  <= TOTAL_W'(lc_r);
            out_od_r     <= res_od_r;
            out_id_r     <= res_id_r;
            out_fo_r     <= res_fo_r;
            out_fi_r     <= res_fi_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_link_pos        = out_lpos_r;
  assign out_link_source     = out_ls_r;
  assign out_link_dest       = out_ld_r;
  assign out_link_label      = out_ll_r;
  assign out_total_links     = out_total_r;
  assign out_node_out_degree = out_od_r;
  assign out_node_in_degree  = out_id_r;
  assign out_node_first_out  = out_fo_r;
  assign out_node_first_in   = out_fi_r;
endmodule
`default_nettype wire

### hdl/sete_checker.sv
// Port-level checker of the sorted edge table engine, bound to the top level.
// Depends on sete_pkg and sorted_edge_table_engine_defines.svh.
`default_nettype none
`include "sorted_edge_table_engine_defines.svh"
module sete_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic        [sete_pkg::STATUS_W-1:0] out_status,
  input wire logic signed [sete_pkg::LPOS_W-1:0]   out_link_pos,
  input wire logic        [sete_pkg::TOTAL_W-1:0]  out_total_links
);
  import sete_pkg::*;

  // The engine works on one word at a time.
  `SETE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  // Only defined status codes come out; the codes run from ok up to not indexed.
  `SETE_ASSERT_IMP(a_status_legal, clk, rst_n, out_valid, out_status <= ST_NOT_INDEXED)
  // Every failed word reports no position.
  `SETE_ASSERT_IMP(a_fail_no_pos, clk, rst_n, out_valid && out_status != ST_OK, out_link_pos == 9'sh1FF)
  // A stalled result holds.
  `SETE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_total_links))
endmodule

bind sorted_edge_table_engine sete_checker u_sete_checker (.*);
`default_nettype wire
